[design/upe_pkg.sv]
// ----------------------------------------------------------------------------
// upe_pkg: shared types and constants for the unicycle state predictor
// Q-format constants, CORDIC arctangent table, datapath command encoding.
// ----------------------------------------------------------------------------
package upe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ITERS         = 30;
  localparam int ITER_W        = $clog2(ITERS);
  localparam int DT_W          = 24;
  localparam int PADDR_W       = 3;
  localparam int MUL_W         = 35;
  localparam int PROD_W        = 2 * MUL_W;
  localparam int ANG_W         = 34;

  localparam logic [DT_W-1:0]           STEP_RESET  = 24'd6554;
  localparam logic signed [MUL_W-1:0]   INV_TWO_PI  = 35'sd683565276;
  localparam logic signed [MUL_W-1:0]   HALF_PI     = 35'sd1686629713;
  localparam logic signed [ANG_W-1:0]   CORDIC_GAIN = 34'sd652032874;
  localparam logic [PADDR_W-1:0]        ADDR_STEP   = 3'd0;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_PHASE, OP_ANGLE, OP_INIT, OP_ROT, OP_MULC, OP_MULS,
    OP_DX, OP_DY, OP_DH, OP_DV, OP_FIN, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ITER_W-1:0] iter;
  } cmd_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
    case (i)
      5'd0:    atan_q30 = 34'sd843314857;
      5'd1:    atan_q30 = 34'sd497837829;
      5'd2:    atan_q30 = 34'sd263043837;
      5'd3:    atan_q30 = 34'sd133525159;
      5'd4:    atan_q30 = 34'sd67021687;
      5'd5:    atan_q30 = 34'sd33543516;
      5'd6:    atan_q30 = 34'sd16775851;
      5'd7:    atan_q30 = 34'sd8388437;
      5'd8:    atan_q30 = 34'sd4194283;
      5'd9:    atan_q30 = 34'sd2097149;
      default: atan_q30 = ANG_W'(34'sd1 <<< (5'd30 - i));
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W:0] v);
    if (v > (PROD_W+1)'(33'sd2147483647))
      sat32 = 32'sh7fffffff;
    else if (v < -(PROD_W+1)'(33'sd2147483648))
      sat32 = 32'sh80000000;
    else
      sat32 = v[31:0];
  endfunction

endpackage

[design/upe_if.sv]
// ----------------------------------------------------------------------------
// upe_if: stream channels of the unicycle state predictor
// Valid/ready channels for control items and predicted states.
// ----------------------------------------------------------------------------
interface upe_in_if;
  logic               valid;
  logic               ready;
  logic               load_start;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_heading;
  logic signed [31:0] start_speed;
  logic signed [31:0] turn_rate;
  logic signed [31:0] acceleration;
  logic               final_step;
  modport source (output valid, load_start, start_x, start_y, start_heading, start_speed,
                  turn_rate, acceleration, final_step, input ready);
  modport sink (input valid, load_start, start_x, start_y, start_heading, start_speed,
                turn_rate, acceleration, final_step, output ready);
endinterface

interface upe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;
  logic signed [31:0] speed;
  logic               horizon_end;
  modport source (output valid, pos_x, pos_y, heading, speed, horizon_end, input ready);
  modport sink (input valid, pos_x, pos_y, heading, speed, horizon_end, output ready);
endinterface

[design/upe_ctrl.sv]
// ----------------------------------------------------------------------------
// upe_ctrl: sequencer of the unicycle state predictor
// Steps the shared multiplier and CORDIC through one item, owns handshakes.
// ----------------------------------------------------------------------------
module upe_ctrl
  import upe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_load,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_PHASE, S_ANGLE, S_INIT, S_ROT, S_MULC, S_MULS,
    S_DX, S_DY, S_DH, S_DV, S_FIN, S_EMIT
  } state_t;

  state_t            state;
  logic [ITER_W-1:0] iter;
  logic              emit;

  assign in_ready = (state == S_IDLE);
  assign emit     = (state == S_EMIT) && (!out_valid || out_ready);

  always_comb begin
    cmd.iter = iter;
    case (state)
      S_IDLE:  cmd.op = (in_valid) ? OP_CAPTURE : OP_NONE;
      S_PHASE: cmd.op = OP_PHASE;
      S_ANGLE: cmd.op = OP_ANGLE;
      S_INIT:  cmd.op = OP_INIT;
      S_ROT:   cmd.op = OP_ROT;
      S_MULC:  cmd.op = OP_MULC;
      S_MULS:  cmd.op = OP_MULS;
      S_DX:    cmd.op = OP_DX;
      S_DY:    cmd.op = OP_DY;
      S_DH:    cmd.op = OP_DH;
      S_DV:    cmd.op = OP_DV;
      S_FIN:   cmd.op = OP_FIN;
      S_EMIT:  cmd.op = emit ? OP_EMIT : OP_NONE;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE:  if (in_valid) state <= in_load ? S_EMIT : S_PHASE;
        S_PHASE: state <= S_ANGLE;
        S_ANGLE: state <= S_INIT;
        S_INIT: begin
          iter  <= '0;
          state <= S_ROT;
        end
        S_ROT: begin
          iter <= iter + 1'b1;
          if (iter == ITER_W'(ITERS - 1)) state <= S_MULC;
        end
        S_MULC:  state <= S_MULS;
        S_MULS:  state <= S_DX;
        S_DX:    state <= S_DY;
        S_DY:    state <= S_DH;
        S_DH:    state <= S_DV;
        S_DV:    state <= S_FIN;
        S_FIN:   state <= S_EMIT;
        S_EMIT: begin
          if (emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_iter_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ROT |-> iter < ITER_W'(ITERS))
    else $error("rotation index out of range");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after a transaction");
  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result raised outside emit");
`endif

endmodule

[design/upe_dp.sv]
// ----------------------------------------------------------------------------
// upe_dp: datapath of the unicycle state predictor
// Pose state, shared multiplier, CORDIC rotator and output register.
// ----------------------------------------------------------------------------
module upe_dp
  import upe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [DT_W-1:0]    step_time,
  input  logic               in_load,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_heading,
  input  logic signed [31:0] in_speed,
  input  logic signed [31:0] in_rate,
  input  logic signed [31:0] in_accel,
  input  logic               in_final,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_heading,
  output logic signed [31:0] out_speed,
  output logic               out_end
);

  logic signed [31:0]       cur_x, cur_y, cur_heading, cur_speed;
  logic signed [31:0]       rate, accel;
  logic                     fin_flag, flip;
  logic signed [PROD_W-1:0] prod;
  logic signed [ANG_W-1:0]  cx, cy, cz, mc, ms;
  logic signed [MUL_W-1:0]  mul_a, mul_b, dt_ext;
  logic [31:0]              ph;
  logic signed [31:0]       p;
  logic signed [ANG_W-1:0]  dx, dy, at, cos_v, sin_v;
  logic signed [PROD_W:0]   delta, sum_x, sum_y, sum_h, sum_v;

  assign dt_ext = MUL_W'($signed({1'b0, step_time}));
  assign ph     = prod[FRAC_BITS+31:FRAC_BITS];
  assign p      = $signed({ph[31] ^ (ph[31] ^ ph[30]), ph[30:0]});
  assign dx     = cy >>> cmd.iter;
  assign dy     = cx >>> cmd.iter;
  assign at     = atan_q30(cmd.iter);
  assign cos_v  = flip ? -cx : cx;
  assign sin_v  = flip ? -cy : cy;
  assign delta  = (PROD_W+1)'(prod >>> FRAC_BITS);
  assign sum_x  = (PROD_W+1)'(cur_x) + delta;
  assign sum_y  = (PROD_W+1)'(cur_y) + delta;
  assign sum_h  = (PROD_W+1)'(cur_heading) + delta;
  assign sum_v  = (PROD_W+1)'(cur_speed) + delta;

  always_comb begin
    mul_a = MUL_W'(cur_speed);
    mul_b = MUL_W'(cos_v);
    case (cmd.op)
      OP_PHASE: begin
        mul_a = MUL_W'(cur_heading);
        mul_b = INV_TWO_PI;
      end
      OP_ANGLE: begin
        mul_a = MUL_W'(p);
        mul_b = HALF_PI;
      end
      OP_MULS: mul_b = MUL_W'(sin_v);
      OP_DX: begin
        mul_a = MUL_W'(mc);
        mul_b = dt_ext;
      end
      OP_DY: begin
        mul_a = MUL_W'(ms);
        mul_b = dt_ext;
      end
      OP_DH: begin
        mul_a = MUL_W'(rate);
        mul_b = dt_ext;
      end
      OP_DV: begin
        mul_a = MUL_W'(accel);
        mul_b = dt_ext;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      cur_heading <= '0;
      cur_speed   <= '0;
    end else begin
      prod <= mul_a * mul_b;
      case (cmd.op)
        OP_CAPTURE: begin
          rate     <= in_rate;
          accel    <= in_accel;
          fin_flag <= in_final;
          if (in_load) begin
            cur_x       <= in_x;
            cur_y       <= in_y;
            cur_heading <= in_heading;
            cur_speed   <= in_speed;
          end
        end
        OP_ANGLE: flip <= ph[31] ^ ph[30];
        OP_INIT: begin
          cz <= ANG_W'(prod >>> 30);
          cx <= CORDIC_GAIN;
          cy <= '0;
        end
        OP_ROT: begin
          if (!cz[ANG_W-1]) begin
            cx <= cx - dx;
            cy <= cy + dy;
            cz <= cz - at;
          end else begin
            cx <= cx + dx;
            cy <= cy - dy;
            cz <= cz + at;
          end
        end
        OP_MULS: mc <= prod[63:30];
        OP_DX:   ms <= prod[63:30];
        OP_DY:   cur_x <= sat32(sum_x);
        OP_DH:   cur_y <= sat32(sum_y);
        OP_DV:   cur_heading <= sat32(sum_h);
        OP_FIN:  cur_speed <= sat32(sum_v);
        OP_EMIT: begin
          out_x       <= cur_x;
          out_y       <= cur_y;
          out_heading <= cur_heading;
          out_speed   <= cur_speed;
          out_end     <= fin_flag;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/unicycle_euler_state_predictor_unit.sv]
// ----------------------------------------------------------------------------
// unicycle_euler_state_predictor_unit: unicycle pose predictor, Euler steps
// Loads a start pose or integrates one control pair over step_time.
// ----------------------------------------------------------------------------
//  channel   dir   protocol     payload
//  in_ch     in    valid/ready  load_start, start pose, control pair, final_step
//  out_ch    out   valid/ready  pos_x, pos_y, heading, speed, horizon_end
//  apb       in    APB write    step_time at 0x0
//
//  A control item runs the 30 CORDIC rotations and eight passes through
//  the one shared multiplier between transaction and result. A load item
//  goes straight from capture to emit. One item is in work at a time.
//  Reset clears the pose to zero and step_time to 6554.
//  A result held by out_ch stalls only the emit of the next item.
module unicycle_euler_state_predictor_unit
  import upe_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  logic               clk,
  input  logic               rst,
  upe_in_if.sink             in_ch,
  upe_out_if.source          out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [DT_W-1:0] step_time;
  cmd_t            cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_STEP) ? {{(32 - DT_W){1'b0}}, step_time} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_time <= STEP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_STEP) begin
      step_time <= pwdata[DT_W-1:0];
    end
  end

  upe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_load   (in_ch.load_start),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  upe_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .step_time   (step_time),
    .in_load     (in_ch.load_start),
    .in_x        (in_ch.start_x),
    .in_y        (in_ch.start_y),
    .in_heading  (in_ch.start_heading),
    .in_speed    (in_ch.start_speed),
    .in_rate     (in_ch.turn_rate),
    .in_accel    (in_ch.acceleration),
    .in_final    (in_ch.final_step),
    .out_x       (out_ch.pos_x),
    .out_y       (out_ch.pos_y),
    .out_heading (out_ch.heading),
    .out_speed   (out_ch.speed),
    .out_end     (out_ch.horizon_end)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the unicycle Euler state predictor
// Drives load and control items through the input channel, writes step_time
// over APB between phases, and checks every predicted state against an
// in-bench fixed-point predictor (CORDIC, floor scaling, saturation).
// ----------------------------------------------------------------------------
module tb_top;
  import upe_pkg::*;

  typedef struct packed {
    logic        ld;
    logic [31:0] sx, sy, sh, sv, rate, acc;
    logic        fin;
  } item_t;

  typedef struct packed {
    logic [31:0] px, py, hd, sp;
    logic        he;
  } pose_t;

  typedef struct {
    item_t it;
    logic  chk;
    pose_t exp;
  } row_t;

  localparam int WDOG_LIMIT = 20000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  upe_in_if  in_ch ();
  upe_out_if out_ch ();

  unicycle_euler_state_predictor_unit u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  longint pm_x, pm_y, pm_h, pm_v;
  logic [23:0] pm_dt;
  pose_t pose_q[$];
  logic  fixed_q[$];
  pose_t fixed_exp_q[$];
  int errors;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  int wdog;

  longint atan_tab[30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint dt_scale(longint v, logic [23:0] dt);
    return (v * longint'({40'd0, dt})) >>> 16;
  endfunction

  task automatic heading_sincos(input longint yaw, output longint s, output longint c);
    longint prod, p, z, x, y, dx, dy;
    logic [31:0] ph;
    logic flip;
    prod = yaw * 64'sd683565276;
    ph = prod[47:16];
    flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
    if (flip) ph = ph - 32'h8000_0000;
    p = longint'(signed'(ph));
    z = (p * 64'sd1686629713) >>> 30;
    x = 64'sd652032874;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic predict_pose(input item_t it, output pose_t r);
    longint s, c;
    longint nx, ny, nh, nv;
    if (it.ld) begin
      pm_x = longint'(signed'(it.sx));
      pm_y = longint'(signed'(it.sy));
      pm_h = longint'(signed'(it.sh));
      pm_v = longint'(signed'(it.sv));
    end else begin
      heading_sincos(pm_h, s, c);
      nx = pm_x + dt_scale((pm_v * c) >>> 30, pm_dt);
      ny = pm_y + dt_scale((pm_v * s) >>> 30, pm_dt);
      nh = pm_h + dt_scale(longint'(signed'(it.rate)), pm_dt);
      nv = pm_v + dt_scale(longint'(signed'(it.acc)), pm_dt);
      pm_x = clamp32(nx); pm_y = clamp32(ny);
      pm_h = clamp32(nh); pm_v = clamp32(nv);
    end
    r.px = pm_x[31:0]; r.py = pm_y[31:0]; r.hd = pm_h[31:0]; r.sp = pm_v[31:0];
    r.he = it.fin;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // watchdog
  initial begin
    wdog = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("watchdog expired");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // result sink and checker
  initial begin
    pose_t want, got;
    logic fx;
    pose_t fexp;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.pos_x, out_ch.pos_y, out_ch.heading, out_ch.speed,
                out_ch.horizon_end};
        if (pose_q.size() == 0) begin
          report_mismatch("unexpected transaction", got.px, 32'h0);
        end else begin
          want = pose_q.pop_front();
          fx = fixed_q.pop_front();
          fexp = fixed_exp_q.pop_front();
          if (fx && fexp != want) report_mismatch("table row", fexp.px, want.px);
          if (got.px !== want.px) report_mismatch("pos_x", got.px, want.px);
          if (got.py !== want.py) report_mismatch("pos_y", got.py, want.py);
          if (got.hd !== want.hd) report_mismatch("heading", got.hd, want.hd);
          if (got.sp !== want.sp) report_mismatch("speed", got.sp, want.sp);
          if (got.he !== want.he) report_mismatch("horizon_end", got.he, want.he);
        end
      end
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= a; pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (a == ADDR_STEP) pm_dt = d[23:0];
  endtask

  task automatic send_item(input item_t it, input logic chk, input pose_t fexp);
    pose_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.load_start <= it.ld;
    in_ch.start_x <= it.sx; in_ch.start_y <= it.sy;
    in_ch.start_heading <= it.sh; in_ch.start_speed <= it.sv;
    in_ch.turn_rate <= it.rate; in_ch.acceleration <= it.acc;
    in_ch.final_step <= it.fin;
    do @(posedge clk); while (!in_ch.ready);
    predict_pose(it, r);
    pose_q = {pose_q, r};
    fixed_q = {fixed_q, chk};
    fixed_exp_q = {fixed_exp_q, fexp};
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      3: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t rand_item(input bit ld);
    item_t it;
    it.ld = ld;
    it.sx = rand_word(); it.sy = rand_word();
    it.sh = ($urandom_range(3) == 0) ? rand_word()
            : ($urandom_range(32'h000c_0000) - 32'h0006_0000);
    it.sv = rand_word(); it.rate = rand_word(); it.acc = rand_word();
    it.fin = $urandom_range(1);
    return it;
  endfunction

  row_t dir_tab[$];

  task automatic add_row(input item_t it, input logic chk, input pose_t e);
    row_t r;
    r.it = it; r.chk = chk; r.exp = e;
    dir_tab = {dir_tab, r};
  endtask

  initial begin
    item_t it;
    logic [31:0] dt_set[6];
    int phase_pct_s[4], phase_pct_r[4];
    errors = 0; hold_cycles = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    pm_x = 0; pm_y = 0; pm_h = 0; pm_v = 0; pm_dt = 24'd6554;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.load_start = 1'b0;
    in_ch.start_x = '0; in_ch.start_y = '0; in_ch.start_heading = '0;
    in_ch.start_speed = '0; in_ch.turn_rate = '0; in_ch.acceleration = '0;
    in_ch.final_step = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // after reset, zero speed: only heading and speed move
    add_row('{1'b0, 32'h1234, 32'h1234, 32'h1234, 32'h1234, 32'h0001_0000,
              32'h0002_0000, 1'b1}, 1'b1,
            '{32'd0, 32'd0, 32'd6554, 32'd13108, 1'b1});
    add_row('{1'b1, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff,
              32'hffff_ffff, 32'hffff_ffff, 1'b0}, 1'b1,
            '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 1'b0});
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff,
              1'b1}, 1'b0, '0);
    add_row('{1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
              32'h0, 32'h0, 1'b1}, 1'b1,
            '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b1});
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000,
              1'b0}, 1'b0, '0);
    add_row('{1'b1, 32'h0, 32'h0, 32'h0001_921f, 32'h000a_0000, 32'h0, 32'h0,
              1'b0}, 1'b0, '0);
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 32'h0, 32'h0, 32'h0003_243f, 32'h000a_0000, 32'h0, 32'h0,
              1'b0}, 1'b0, '0);
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0);
    add_row('{1'b1, 32'h0, 32'h0, 32'hfffc_dbc1, 32'hfff6_0000, 32'h0, 32'h0,
              1'b0}, 1'b0, '0);
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hffff_0000,
              1'b1}, 1'b0, '0);
    add_row('{1'b1, 32'h0, 32'h0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 32'h0,
              1'b0}, 1'b0, '0);
    add_row('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0);
    foreach (dir_tab[i]) send_item(dir_tab[i].it, dir_tab[i].chk, dir_tab[i].exp);
    drain_block();

    // zero step time keeps the state
    apb_write(ADDR_STEP, 32'h0);
    send_item('{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
                1'b1}, 1'b0, '0);
    drain_block();

    dt_set = '{32'd6554, 32'hffff_ffff, 32'd1, 32'd65536, 32'h0000_3000,
               32'h00ff_ffff};
    phase_pct_s = '{0, 68, 0, 17};
    phase_pct_r = '{0, 0, 68, 17};
    for (int ph = 0; ph < 8; ph++) begin
      apb_write(ADDR_STEP, dt_set[ph % 6]);
      send_idle_pct = phase_pct_s[ph % 4];
      recv_stall_pct = phase_pct_r[ph % 4];
      if (ph == 2) hold_cycles = 400;
      for (int n = 0; n < 250; n++) begin
        if ($urandom_range(7) == 0) it = rand_item(1'b1);
        else it = rand_item(1'b0);
        send_item(it, 1'b0, '0);
        if (n == 120 && ph == 5) begin
          in_ch.valid <= 1'b0;
          while (pose_q.size() != 0) @(negedge clk);
        end
      end
      drain_block();
    end

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
